[sv/dcctbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcctbe_pkg
// Shared types and constants of the dcc track bit encoder.
// ----------------------------------------------------------------------------
package dcctbe_pkg;

   // item kinds
   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_WRITE   = 3'd1,
      MODE_PUBLISH = 3'd2,
      MODE_START   = 3'd3,
      MODE_STOP    = 3'd4
   } mode_type;

   // bit phase of the track stream
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_PREAMBLE = 3'd1,
      PH_START    = 3'd2,
      PH_DATA     = 3'd3,
      PH_END      = 3'd4
   } phase_type;

   // result item
   typedef struct packed {
      logic toggle;
      logic packet_done;
      logic cutout_begin;
      logic idle;
      logic loaded;
   } status_type;

   localparam logic [2:0] MSB_BIT_POS     = 3'd7;
   localparam logic [1:0] ONE_HALF_TICKS  = 2'd1;
   localparam logic [1:0] ZERO_HALF_TICKS = 2'd2;

endpackage : dcctbe_pkg
`default_nettype wire

[sv/dcctbe_byte_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcctbe_byte_store
// Packet byte registers with one write port and a single-bit read port.
// ----------------------------------------------------------------------------
module dcctbe_byte_store #(
   parameter int MAX_BYTES = 8
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [2:0]                         wr_slot,
   input  wire logic [7:0]                         wr_data,
   input  wire logic [$clog2(MAX_BYTES + 1)-1:0]   rd_pos,
   input  wire logic [2:0]                         rd_bit,
   output logic                                    rd_data
);

   localparam int BP_W  = $clog2(MAX_BYTES + 1);
   localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

   logic [7:0] bytes_ff [MAX_BYTES];
   logic [7:0] slot_ext;
   logic [7:0] pos_ext;
   logic       slot_ok;

   assign slot_ext = {5'd0, wr_slot};
   assign pos_ext  = 8'(rd_pos);
   assign slot_ok  = ({2'd0, wr_slot} < 5'(MAX_BYTES));

   always_ff @(posedge clock) begin
      if (wr_en && slot_ok) begin
         bytes_ff[slot_ext[IDX_W-1:0]] <= wr_data;
      end
   end

   // positions past the end read as zero
   always_comb begin
      rd_data = 1'b0;
      if (rd_pos < BP_W'(MAX_BYTES)) begin
         rd_data = bytes_ff[pos_ext[IDX_W-1:0]][rd_bit];
      end
   end

endmodule : dcctbe_byte_store
`default_nettype wire

[sv/dcctbe_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcctbe_sequencer
// Bit timing and packet phase state; computes the result of each item.
// ----------------------------------------------------------------------------
module dcctbe_sequencer
   import dcctbe_pkg::*;
#(
   parameter int MAX_BYTES = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               item_fire,
   input  wire logic [2:0]                         item_mode,
   input  wire logic [7:0]                         item_total,
   input  wire logic [7:0]                         item_preamble,
   input  wire logic                               cutout_enable,
   input  wire logic                               data_bit,
   output logic      [$clog2(MAX_BYTES + 1)-1:0]   rd_pos,
   output logic      [2:0]                         rd_bit,
   output status_type                              status
);

   localparam int BP_W = $clog2(MAX_BYTES + 1);

   logic             running_ff,  running_in;
   phase_type        phase_ff,    phase_in;
   logic             half_ff,     half_in;
   logic [1:0]       tick_ff,     tick_in;
   logic             one_ff,      one_in;
   logic             toggle_ff,   toggle_in;
   logic             cut_pend_ff, cut_pend_in;
   logic             ready_ff,    ready_in;
   logic [7:0]       pre_left_ff, pre_left_in;
   logic [BP_W-1:0]  byte_pos_ff, byte_pos_in;
   logic [2:0]       bit_pos_ff,  bit_pos_in;
   logic [BP_W-1:0]  pkt_len_ff,  pkt_len_in;
   logic [7:0]       pre_set_ff,  pre_set_in;

   logic             run_tick;
   logic [1:0]       tick_inc;
   logic             half_done;
   logic [BP_W-1:0]  byte_pos_inc;
   logic [7:0]       pre_left_dec;

   assign run_tick     = item_fire && (mode_type'(item_mode) == MODE_TICK) && running_ff;
   assign tick_inc     = tick_ff + 2'd1;
   assign half_done    = one_ff ? (tick_inc >= ONE_HALF_TICKS)
                              : (tick_inc >= ZERO_HALF_TICKS);
   assign byte_pos_inc = byte_pos_ff + BP_W'(1);
   assign pre_left_dec = pre_left_ff - 8'd1;

   // next data bit: msb of the byte after a start bit, else the following bit
   assign rd_pos = byte_pos_ff;
   assign rd_bit = (phase_ff == PH_START) ? MSB_BIT_POS : (bit_pos_ff - 3'd1);

   // next state
   always_comb begin
      running_in  = running_ff;
      phase_in    = phase_ff;
      half_in     = half_ff;
      tick_in     = tick_ff;
      one_in      = one_ff;
      toggle_in   = toggle_ff;
      cut_pend_in = cut_pend_ff;
      ready_in    = ready_ff;
      pre_left_in = pre_left_ff;
      byte_pos_in = byte_pos_ff;
      bit_pos_in  = bit_pos_ff;
      pkt_len_in  = pkt_len_ff;
      pre_set_in  = pre_set_ff;
      if (item_fire) begin
         unique case (mode_type'(item_mode))
            MODE_TICK: begin
               if (!running_ff) begin
                  toggle_in = 1'b0;
               end else begin
                  cut_pend_in = 1'b0;
                  tick_in     = tick_inc;
                  toggle_in   = 1'b0;
                  if (half_done) begin
                     tick_in   = 2'd0;
                     toggle_in = 1'b1;
                     if (!half_ff) begin
                        half_in = 1'b1;
                     end else begin
                        half_in = 1'b0;
                        unique case (phase_ff)
                           PH_IDLE: begin
                              if (ready_ff) begin
                                 pre_left_in = pre_set_ff;
                                 phase_in    = PH_PREAMBLE;
                              end
                              one_in = 1'b1;
                           end
                           PH_PREAMBLE: begin
                              pre_left_in = pre_left_dec;
                              if (pre_left_dec == 8'd0) begin
                                 phase_in    = PH_START;
                                 byte_pos_in = '0;
                                 one_in      = 1'b0;
                              end else begin
                                 one_in = 1'b1;
                              end
                           end
                           PH_START: begin
                              phase_in   = PH_DATA;
                              bit_pos_in = MSB_BIT_POS;
                              one_in     = data_bit;
                           end
                           PH_DATA: begin
                              if (bit_pos_ff == 3'd0) begin
                                 byte_pos_in = byte_pos_inc;
                                 if (byte_pos_inc >= pkt_len_ff) begin
                                    phase_in = PH_END;
                                    one_in   = 1'b1;
                                 end else begin
                                    phase_in = PH_START;
                                    one_in   = 1'b0;
                                 end
                              end else begin
                                 bit_pos_in = bit_pos_ff - 3'd1;
                                 one_in     = data_bit;
                              end
                           end
                           PH_END: begin
                              cut_pend_in = cutout_enable;
                              ready_in    = 1'b0;
                              phase_in    = PH_IDLE;
                              one_in      = 1'b1;
                           end
                           default: begin
                              phase_in = PH_IDLE;
                              one_in   = 1'b1;
                           end
                        endcase
                     end
                  end
               end
            end
            MODE_WRITE: begin
               // bytes land in the byte store
            end
            MODE_PUBLISH: begin
               pkt_len_in = (item_total > 8'(MAX_BYTES)) ? BP_W'(MAX_BYTES)
                                                          : item_total[BP_W-1:0];
               pre_set_in = item_preamble;
               ready_in   = 1'b1;
            end
            MODE_START: begin
               running_in  = 1'b1;
               phase_in    = PH_IDLE;
               half_in     = 1'b0;
               toggle_in   = 1'b1;
               cut_pend_in = 1'b0;
            end
            MODE_STOP: begin
               running_in  = 1'b0;
               phase_in    = PH_IDLE;
               cut_pend_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // result of the item
   always_comb begin
      status.toggle       = toggle_in;
      status.packet_done  = run_tick && half_done && half_ff && (phase_ff == PH_END);
      status.cutout_begin = run_tick && cut_pend_ff && cutout_enable;
      status.idle         = (phase_in == PH_IDLE);
      status.loaded       = ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         phase_ff    <= PH_IDLE;
         half_ff     <= 1'b0;
         tick_ff     <= 2'd0;
         one_ff      <= 1'b1;
         toggle_ff   <= 1'b0;
         cut_pend_ff <= 1'b0;
         ready_ff    <= 1'b0;
         pre_left_ff <= 8'd0;
         byte_pos_ff <= '0;
         bit_pos_ff  <= 3'd0;
         pkt_len_ff  <= '0;
         pre_set_ff  <= 8'd0;
      end else begin
         running_ff  <= running_in;
         phase_ff    <= phase_in;
         half_ff     <= half_in;
         tick_ff     <= tick_in;
         one_ff      <= one_in;
         toggle_ff   <= toggle_in;
         cut_pend_ff <= cut_pend_in;
         ready_ff    <= ready_in;
         pre_left_ff <= pre_left_in;
         byte_pos_ff <= byte_pos_in;
         bit_pos_ff  <= bit_pos_in;
         pkt_len_ff  <= pkt_len_in;
         pre_set_ff  <= pre_set_in;
      end
   end

endmodule : dcctbe_sequencer
`default_nettype wire

[sv/dcc_track_bit_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_track_bit_encoder
// DCC track bit stream encoder, one timer tick or register access per item.
// ----------------------------------------------------------------------------
// Every accepted item produces exactly one result item. Tick items advance
// the bit timing (a one-bit half lasts one tick, a zero-bit half two); other
// items write a packet byte, publish the packet header, start or stop the
// stream. The block takes one item per clock while no stalled result holds
// it back: the item is applied to the state at the edge it is accepted and
// its result enters the output register at that same edge. req_ready stays
// high while that register is empty or drains, so a stalled result holds
// back input only while it waits. csr_wr_en loads cutout_enable with no wait.
// ----------------------------------------------------------------------------
module dcc_track_bit_encoder
   import dcctbe_pkg::*;
#(
   parameter int MAX_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   // input items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [2:0]  req_byte_slot,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [7:0]  req_byte_total,
   input  wire logic [7:0]  req_preamble_length,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_toggle,
   output logic             rsp_packet_done,
   output logic             rsp_cutout_begin,
   output logic             rsp_idle,
   output logic             rsp_loaded
);

   localparam int BP_W = $clog2(MAX_BYTES + 1);

   logic             cut_en_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   status_type       item_status;
   logic             item_fire;
   logic             byte_wr;
   logic             data_bit;
   logic [BP_W-1:0]  rd_pos;
   logic [2:0]       rd_bit;

   // accept while the output register is empty or drains this cycle
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign item_fire    = req_valid && req_ready;
   assign rsp_valid_in = item_fire || (rsp_valid_ff && !rsp_ready);
   assign byte_wr      = item_fire && (mode_type'(req_mode) == MODE_WRITE);

   // packet bytes, read one bit at a time by the sequencer
   dcctbe_byte_store #(
      .MAX_BYTES (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (byte_wr),
      .wr_slot (req_byte_slot),
      .wr_data (req_byte_value),
      .rd_pos  (rd_pos),
      .rd_bit  (rd_bit),
      .rd_data (data_bit)
   );

   // bit timing and packet phase
   dcctbe_sequencer #(
      .MAX_BYTES (MAX_BYTES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .item_fire     (item_fire),
      .item_mode     (req_mode),
      .item_total    (req_byte_total),
      .item_preamble (req_preamble_length),
      .cutout_enable (cut_en_ff),
      .data_bit      (data_bit),
      .rd_pos        (rd_pos),
      .rd_bit        (rd_bit),
      .status        (item_status)
   );

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         cut_en_ff <= csr_wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         rsp_status_ff <= item_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_toggle       = rsp_status_ff.toggle;
   assign rsp_packet_done  = rsp_status_ff.packet_done;
   assign rsp_cutout_begin = rsp_status_ff.cutout_begin;
   assign rsp_idle         = rsp_status_ff.idle;
   assign rsp_loaded       = rsp_status_ff.loaded;

   // a finished packet is released and the stream is back at idle
   a_done_releases: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff.packet_done |-> rsp_status_ff.idle
                                                 && !rsp_status_ff.loaded)
      else $error("packet_done without release to idle");

   // the cutout strobe never shares a tick with the end of a packet
   a_done_cut_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_status_ff.packet_done && rsp_status_ff.cutout_begin))
      else $error("packet_done and cutout_begin in one item");

   // start answers with a pending toggle at idle
   a_start_result: assert property (@(posedge clock) disable iff (reset)
      item_fire && (mode_type'(req_mode) == MODE_START)
      |=> rsp_valid_ff && rsp_status_ff.toggle && rsp_status_ff.idle)
      else $error("start item result wrong");

   // stop answers idle with no strobes
   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      item_fire && (mode_type'(req_mode) == MODE_STOP)
      |=> rsp_valid_ff && rsp_status_ff.idle && !rsp_status_ff.packet_done
          && !rsp_status_ff.cutout_begin)
      else $error("stop item result wrong");

endmodule : dcc_track_bit_encoder
`default_nettype wire
